@@ design/mcw_pkg.sv @@
// shared types and constants for the stick to mecanum wheel speed block
// no dependencies; imported by mcw_lane, mcw_mix and the top level
`default_nettype none

package mcw_pkg;

  // field widths
  localparam int CH_W       = 11;
  localparam int DZ_W       = 10;
  localparam int LIM_W      = 15;
  localparam int GAIN_W     = 16;
  localparam int SPD_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // datapath widths
  localparam int OFF_W      = CH_W + 1;           // signed channel offset
  localparam int PROD_W     = CH_W + LIM_W;       // |offset| * speed_limit
  localparam int DIV_BITS   = LIM_W;              // quotient bits below the clamp
  localparam int ROT_PROD_W = SPD_W + GAIN_W + 1; // vz * gain, signed
  localparam int ROT_SHIFT  = 8;                  // Q8.8 gain
  localparam int ROT_W      = ROT_PROD_W - ROT_SHIFT;
  localparam int SUM_W      = ROT_W + 2;          // three-term wheel sum

  // pipeline depth: offset stage, multiply stage, divide steps, sign stage
  localparam int LANE_STAGES = 2 + DIV_BITS + 1;
  localparam int MIX_STAGES  = 2;
  localparam int NSTAGE      = LANE_STAGES + MIX_STAGES;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_MIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_MAX    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_CENTER = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_SPAN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ROTATE_GAIN    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_LAYOUT_O       = 3'd7;

  typedef logic signed [SPD_W-1:0] speed_t;

  typedef struct packed {
    logic [CH_W-1:0]   channel_min;
    logic [CH_W-1:0]   channel_max;
    logic [CH_W-1:0]   channel_center;
    logic [DZ_W-1:0]   dead_zone;
    logic [CH_W-1:0]   channel_span;
    logic [LIM_W-1:0]  speed_limit;
    logic [GAIN_W-1:0] rotate_gain;
    logic              layout_o;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    channel_min:    11'd200,
    channel_max:    11'd1800,
    channel_center: 11'd1000,
    dead_zone:      10'd50,
    channel_span:   11'd800,
    speed_limit:    15'd1000,
    rotate_gain:    16'd256,
    layout_o:       1'b0
  };

endpackage

`default_nettype wire

@@ design/mcw_lane.sv @@
// one channel lane: range and dead zone check, scale by speed limit,
// restoring divide by the span one quotient bit per stage, clamp and sign; uses mcw_pkg
`default_nettype none

module mcw_lane (
  input  wire logic                    clk,
  input  wire logic                    en,
  input  wire mcw_pkg::cfg_t           cfg,
  input  wire logic [mcw_pkg::CH_W-1:0] raw,
  output mcw_pkg::speed_t              vel
);
  import mcw_pkg::*;

  typedef struct packed {
    logic zero; // result forced to zero
    logic neg;  // offset below center
    logic big;  // |offset| >= span, result clamps to the limit
  } flags_t;

  logic signed [OFF_W-1:0] off;
  logic [CH_W-1:0]         abs_off;
  flags_t                  flags_nxt;

  // stage 1: offset, magnitude and special cases
  always_comb begin
    off              = $signed({1'b0, raw}) - $signed({1'b0, cfg.channel_center});
    flags_nxt.neg    = off[OFF_W-1];
    abs_off          = flags_nxt.neg ? CH_W'(-off) : CH_W'(off);
    flags_nxt.zero   = (raw < cfg.channel_min) || (raw > cfg.channel_max) ||
                       (abs_off < {1'b0, cfg.dead_zone}) || (abs_off == '0);
    flags_nxt.big    = (abs_off >= cfg.channel_span);
  end

  flags_t          s1_flags_r;
  logic [CH_W-1:0] s1_abs_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_flags_r <= flags_nxt;
      s1_abs_r   <= abs_off;
    end
  end

  // stage 2: scale the magnitude by the speed limit
  flags_t            s2_flags_r;
  logic [PROD_W-1:0] s2_prod_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_flags_r <= s1_flags_r;
      s2_prod_r  <= PROD_W'(s1_abs_r) * PROD_W'(cfg.speed_limit);
    end
  end

  // divide steps, most significant quotient bit first
  flags_t              dv_flags_r [DIV_BITS];
  logic [PROD_W-1:0]   dv_rem_r   [DIV_BITS];
  logic [DIV_BITS-1:0] dv_quo_r   [DIV_BITS];

  for (genvar j = 0; j < DIV_BITS; j++) begin : g_div
    localparam int BIT = DIV_BITS - 1 - j;
    logic [PROD_W-1:0]   rem_in;
    logic [DIV_BITS-1:0] quo_in;
    flags_t              flags_in;
    logic [PROD_W-1:0]   dsh;
    logic                ge;

    if (j == 0) begin : g_first
      assign rem_in   = s2_prod_r;
      assign quo_in   = '0;
      assign flags_in = s2_flags_r;
    end else begin : g_next
      assign rem_in   = dv_rem_r[j-1];
      assign quo_in   = dv_quo_r[j-1];
      assign flags_in = dv_flags_r[j-1];
    end

    assign dsh = PROD_W'(cfg.channel_span) << BIT;
    assign ge  = (rem_in >= dsh);

    always_ff @(posedge clk) begin
      if (en) begin
        dv_flags_r[j] <= flags_in;
        dv_rem_r[j]   <= ge ? (rem_in - dsh) : rem_in;
        dv_quo_r[j]   <= quo_in | (DIV_BITS'(ge) << BIT);
      end
    end
  end

  // last stage: clamp and apply the sign
  logic [LIM_W-1:0] mag;
  logic [SPD_W-1:0] mag_ext;
  speed_t           vel_nxt;
  speed_t           vel_r;
  flags_t           fin;

  always_comb begin
    fin     = dv_flags_r[DIV_BITS-1];
    mag     = fin.big ? cfg.speed_limit : dv_quo_r[DIV_BITS-1];
    mag_ext = SPD_W'(mag);
    if (fin.zero) begin
      vel_nxt = '0;
    end else if (fin.neg) begin
      vel_nxt = $signed(SPD_W'(0) - mag_ext);
    end else begin
      vel_nxt = $signed(mag_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vel_r <= vel_nxt;
    end
  end

  assign vel = vel_r;

endmodule

`default_nettype wire

@@ design/mcw_mix.sv @@
// merge stage: rotation gain multiply, mecanum mix for X or O layout,
// right wheel negation and 16-bit saturation; uses mcw_pkg
`default_nettype none

module mcw_mix (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire mcw_pkg::cfg_t cfg,
  input  wire mcw_pkg::speed_t vx,
  input  wire mcw_pkg::speed_t vy,
  input  wire mcw_pkg::speed_t vz,
  output mcw_pkg::speed_t    body_vx,
  output mcw_pkg::speed_t    body_vy,
  output mcw_pkg::speed_t    body_vz,
  output mcw_pkg::speed_t    wheel_lf,
  output mcw_pkg::speed_t    wheel_rf,
  output mcw_pkg::speed_t    wheel_lb,
  output mcw_pkg::speed_t    wheel_rb
);
  import mcw_pkg::*;

  function automatic speed_t sat16(input logic signed [SUM_W-1:0] v);
    speed_t res;
    if (v > SUM_W'(32767)) begin
      res = 16'sh7fff;
    end else if (v < -SUM_W'(32768)) begin
      res = 16'sh8000;
    end else begin
      res = speed_t'(v);
    end
    return res;
  endfunction

  // stage 1: rotation product
  speed_t                       vx1_r, vy1_r, vz1_r;
  logic signed [ROT_PROD_W-1:0] rot_prod_r;

  always_ff @(posedge clk) begin
    if (en) begin
      vx1_r      <= vx;
      vy1_r      <= vy;
      vz1_r      <= vz;
      rot_prod_r <= vz * $signed({1'b0, cfg.rotate_gain});
    end
  end

  // stage 2: floor shift, wheel sums and saturation
  logic signed [ROT_W-1:0] rot;
  logic signed [SUM_W-1:0] sx, sy, sr;
  logic signed [SUM_W-1:0] lf, rf, lb, rb;

  always_comb begin
    rot = rot_prod_r[ROT_PROD_W-1:ROT_SHIFT];
    sx  = SUM_W'(vx1_r);
    sy  = SUM_W'(vy1_r);
    sr  = SUM_W'(rot);
    if (cfg.layout_o) begin
      lf = sx + sy + sr;
      lb = sx - sy - sr;
      rf = -(sx - sy + sr);
      rb = -(sx + sy - sr);
    end else begin
      lf = sx - sy - sr;
      lb = sx + sy - sr;
      rf = -(sx + sy + sr);
      rb = -(sx - sy + sr);
    end
  end

  speed_t body_vx_r, body_vy_r, body_vz_r;
  speed_t wheel_lf_r, wheel_rf_r, wheel_lb_r, wheel_rb_r;

  always_ff @(posedge clk) begin
    if (en) begin
      body_vx_r  <= vx1_r;
      body_vy_r  <= vy1_r;
      body_vz_r  <= vz1_r;
      wheel_lf_r <= sat16(lf);
      wheel_rf_r <= sat16(rf);
      wheel_lb_r <= sat16(lb);
      wheel_rb_r <= sat16(rb);
    end
  end

  assign body_vx  = body_vx_r;
  assign body_vy  = body_vy_r;
  assign body_vz  = body_vz_r;
  assign wheel_lf = wheel_lf_r;
  assign wheel_rf = wheel_rf_r;
  assign wheel_lb = wheel_lb_r;
  assign wheel_rb = wheel_rb_r;

endmodule

`default_nettype wire

@@ design/stick_to_mecanum_wheel_speeds.sv @@
// top level: config registers, pipeline valid tracking, three channel lanes
// and the wheel mix stage; uses mcw_pkg, mcw_lane, mcw_mix
//
//  channel | direction | handshake            | beat
//  in_     | input     | in_valid / in_ready  | stick_x, stick_y, stick_z
//  out_    | output    | out_valid / out_ready| body speeds and four wheel targets
//  cfg_    | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// one beat enters per cycle unless out_ready stalls the pipeline; each beat passes
// the offset and multiply stages, the 15-step restoring divide and the sign stage
// in each lane, then the rotation multiply and mix stages.
// the whole pipeline advances together whenever the output register is empty
// or being taken, so a stall on out_ready holds every stage.
// rst_n clears the pipeline valids and loads the register defaults; cfg_ready
// is always high.
`default_nettype none

module stick_to_mecanum_wheel_speeds (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [mcw_pkg::CH_W-1:0]        in_stick_x,
  input  wire logic [mcw_pkg::CH_W-1:0]        in_stick_y,
  input  wire logic [mcw_pkg::CH_W-1:0]        in_stick_z,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output mcw_pkg::speed_t                      out_body_vx,
  output mcw_pkg::speed_t                      out_body_vy,
  output mcw_pkg::speed_t                      out_body_vz,
  output mcw_pkg::speed_t                      out_wheel_left_front,
  output mcw_pkg::speed_t                      out_wheel_right_front,
  output mcw_pkg::speed_t                      out_wheel_left_back,
  output mcw_pkg::speed_t                      out_wheel_right_back,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [mcw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [mcw_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import mcw_pkg::*;

  // configuration registers
  cfg_t cfg_r, cfg_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_CHANNEL_MIN:    cfg_nxt.channel_min    = cfg_data[CH_W-1:0];
        REG_CHANNEL_MAX:    cfg_nxt.channel_max    = cfg_data[CH_W-1:0];
        REG_CHANNEL_CENTER: cfg_nxt.channel_center = cfg_data[CH_W-1:0];
        REG_DEAD_ZONE:      cfg_nxt.dead_zone      = cfg_data[DZ_W-1:0];
        REG_CHANNEL_SPAN:   cfg_nxt.channel_span   = cfg_data[CH_W-1:0];
        REG_SPEED_LIMIT:    cfg_nxt.speed_limit    = cfg_data[LIM_W-1:0];
        REG_ROTATE_GAIN:    cfg_nxt.rotate_gain    = cfg_data[GAIN_W-1:0];
        REG_LAYOUT_O:       cfg_nxt.layout_o       = cfg_data[0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // pipeline valids, one per stage, shifted on a global advance
  logic [NSTAGE-1:0] vld_r, vld_nxt;
  logic              adv;

  assign adv       = !vld_r[NSTAGE-1] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld_r[NSTAGE-1];

  always_comb begin
    vld_nxt = vld_r;
    if (adv) begin
      vld_nxt = {vld_r[NSTAGE-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // channel lanes
  speed_t vx, vy, vz;

  mcw_lane u_lane_x (
    .clk (clk),
    .en  (adv),
    .cfg (cfg_r),
    .raw (in_stick_x),
    .vel (vx)
  );

  mcw_lane u_lane_y (
    .clk (clk),
    .en  (adv),
    .cfg (cfg_r),
    .raw (in_stick_y),
    .vel (vy)
  );

  mcw_lane u_lane_z (
    .clk (clk),
    .en  (adv),
    .cfg (cfg_r),
    .raw (in_stick_z),
    .vel (vz)
  );

  // wheel mix and output register
  mcw_mix u_mix (
    .clk      (clk),
    .en       (adv),
    .cfg      (cfg_r),
    .vx       (vx),
    .vy       (vy),
    .vz       (vz),
    .body_vx  (out_body_vx),
    .body_vy  (out_body_vy),
    .body_vz  (out_body_vz),
    .wheel_lf (out_wheel_left_front),
    .wheel_rf (out_wheel_right_front),
    .wheel_lb (out_wheel_left_back),
    .wheel_rb (out_wheel_right_back)
  );

endmodule

`default_nettype wire

@@ design/mcw_checker.sv @@
// port-level checks for the stick to mecanum wheel speed block
// bound to stick_to_mecanum_wheel_speeds; no package dependency
`default_nettype none

module mcw_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] out_body_vx,
  input wire logic [15:0] out_body_vy,
  input wire logic [15:0] out_body_vz,
  input wire logic [15:0] out_wheel_left_front,
  input wire logic [15:0] out_wheel_right_back
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_wheel_left_front) &&
      $stable(out_wheel_right_back) && $stable(out_body_vz))
    else $error("stalled result beat changed");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat valid right after reset");

  // an empty output register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  // body speeds are clamped to the 15-bit limit, never the negative extreme
  a_body_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_body_vx != 16'h8000 && out_body_vy != 16'h8000 &&
      out_body_vz != 16'h8000)
    else $error("body speed outside clamp range");

endmodule

bind stick_to_mecanum_wheel_speeds mcw_checker u_mcw_checker (.*);

`default_nettype wire
